/* hdl/xtea_pkg.sv */
// Shared types, constants and round helpers for the XTEA encrypt pipeline.
package xtea_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int STAGES      = 2 * ROUND_COUNT;
  localparam int WORD_W      = 32;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_IDX_W   = 2;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           key_sel_t;

  localparam word_t GOLDEN_DELTA = 32'h9e37_79b9;

  // configuration register indexes
  localparam cfg_idx_t KEY_IDX_0 = 2'd0;
  localparam cfg_idx_t KEY_IDX_1 = 2'd1;
  localparam cfg_idx_t KEY_IDX_2 = 2'd2;
  localparam cfg_idx_t KEY_IDX_3 = 2'd3;

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // running sum seen by half-round s: even half uses round*delta, odd uses (round+1)*delta
  function automatic word_t stage_sum(input int s);
    logic [63:0] p;
    p = 64'((s + 1) >> 1) * 64'(GOLDEN_DELTA);
    return p[WORD_W-1:0];
  endfunction

  function automatic key_sel_t stage_key(input int s);
    word_t sm;
    sm = stage_sum(s);
    if ((s & 1) == 0) begin
      return sm[1:0];
    end else begin
      return sm[12:11];
    end
  endfunction

endpackage

/* hdl/xtea_in_if.sv */
// Plaintext channel: valid/ready handshake carrying one 64-bit block.
interface xtea_in_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  word_t plain_left;
  word_t plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

/* hdl/xtea_out_if.sv */
// Ciphertext channel: valid/ready handshake carrying one 64-bit block.
interface xtea_out_if;
  import xtea_pkg::*;

  logic  valid;
  logic  ready;
  word_t cipher_left;
  word_t cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

/* hdl/xtea_block_encrypt_core.sv */
// XTEA block encryption: one half-round per pipeline stage, 2-entry output queue.
// Throughput: one item per cycle unless stalled; each stage holds one Feistel half-round.
// The pipeline stalls only when the output queue is full and the last stage holds an item.
// Reset (rst_n low, synchronous) clears all valid bits, the queue and the key words to zero.
module xtea_block_encrypt_core (
  input  logic                clk,
  input  logic                rst_n,
  xtea_in_if.sink             in_ch,
  xtea_out_if.source          out_ch,
  input  logic                cfg_we,
  input  xtea_pkg::cfg_idx_t  cfg_index,
  input  xtea_pkg::word_t     cfg_wdata
);
  import xtea_pkg::*;

  localparam int LAST = STAGES - 1;

  word_t              key_r [KEY_WORDS];
  word_t              lft_r [STAGES];
  word_t              rgt_r [STAGES];
  word_t              lft_nxt [STAGES];
  word_t              rgt_nxt [STAGES];
  logic [STAGES-1:0]  vld_r;
  logic               adv;
  logic               in_fire;

  // output queue
  word_t       q_lft_r [2];
  word_t       q_rgt_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        q_full;
  logic        push;
  logic        pop;

  // key words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_WORDS; k++) begin
        key_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        KEY_IDX_0: key_r[0] <= cfg_wdata;
        KEY_IDX_1: key_r[1] <= cfg_wdata;
        KEY_IDX_2: key_r[2] <= cfg_wdata;
        KEY_IDX_3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign q_full   = (cnt_r == 2'd2);
  assign adv      = !(vld_r[LAST] && q_full);
  assign in_ch.ready = adv;
  assign in_fire  = in_ch.valid && adv;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam word_t    SUM  = stage_sum(s);
    localparam key_sel_t KSEL = stage_key(s);
    word_t l_src;
    word_t r_src;
    word_t tweak;

    if (s == 0) begin : g_first
      assign l_src = in_ch.plain_left;
      assign r_src = in_ch.plain_right;
    end else begin : g_next
      assign l_src = lft_r[s-1];
      assign r_src = rgt_r[s-1];
    end

    assign tweak = SUM + key_r[KSEL];

    if ((s % 2) == 0) begin : g_even
      assign lft_nxt[s] = l_src + (mix_word(r_src) ^ tweak);
      assign rgt_nxt[s] = r_src;
    end else begin : g_odd
      assign lft_nxt[s] = l_src;
      assign rgt_nxt[s] = r_src + (mix_word(l_src) ^ tweak);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lft_r[s] <= lft_nxt[s];
        rgt_r[s] <= rgt_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_fire};
    end
  end

  assign push    = vld_r[LAST] && adv;
  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_lft_r[wr_ptr_r] <= lft_r[LAST];
      q_rgt_r[wr_ptr_r] <= rgt_r[LAST];
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.cipher_left  = q_lft_r[rd_ptr_r];
  assign out_ch.cipher_right = q_rgt_r[rd_ptr_r];

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && !adv) |=> (vld_r[LAST] && $stable(lft_r[LAST]) && $stable(rgt_r[LAST])))
    else $error("last stage lost its item during stall");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !pop) |=> (cnt_r == 2'd2))
    else $error("output queue overflowed");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the XTEA block encrypt core: keyed phases, bursty feed, stalls.
module tb_top;
  import xtea_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;
  localparam int TAIL_WAIT   = 2 * ROUND_COUNT + 8;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    word_t left;
    word_t right;
  } block_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  // Tracks the key, predicts each ciphertext and matches the results in order.
  class cipher_scoreboard;
    word_t  key [KEY_WORDS];
    block_t cipher_q [$];
    int     errors;
    int     received;

    function new();
      foreach (key[i]) key[i] = '0;
      errors   = 0;
      received = 0;
    endfunction

    function void load_key(cfg_idx_t idx, word_t value);
      key[idx] = value;
    endfunction

    function word_t shift_mix(word_t v);
      return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function block_t encipher(word_t l, word_t r);
      word_t  total;
      block_t blk;
      total = '0;
      for (int rnd = 0; rnd < ROUND_COUNT; rnd++) begin
        l = l + (shift_mix(r) ^ (total + key[total[1:0]]));
        total = total + GOLDEN_DELTA;
        r = r + (shift_mix(l) ^ (total + key[total[12:11]]));
      end
      blk.left  = l;
      blk.right = r;
      return blk;
    endfunction

    function void note_plain(word_t l, word_t r);
      cipher_q.push_back(encipher(l, r));
    endfunction

    function void check_cipher(word_t l, word_t r);
      block_t want;
      received++;
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected cipher block %h %h", $time, l, r);
        errors++;
        return;
      end
      want = cipher_q.pop_front();
      if (l !== want.left) begin
        $display("%0t: cipher_left expected %h actual %h", $time, want.left, l);
        errors++;
      end
      if (r !== want.right) begin
        $display("%0t: cipher_right expected %h actual %h", $time, want.right, r);
        errors++;
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  word_t    cfg_wdata;
  int       cycles = 0;

  xtea_in_if  in_ch ();
  xtea_out_if out_ch ();

  cipher_scoreboard sb = new();

  xtea_block_encrypt_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_key(cfg_idx_t idx, word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.load_key(idx, value);
  endtask

  // key may only change with the pipeline empty
  task automatic set_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    drain();
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    cfg_we <= 1'b0;
  endtask

  // leaves valid high; caller lowers it for a gap
  task automatic send_block(word_t l, word_t r);
    in_ch.valid       <= 1'b1;
    in_ch.plain_left  <= l;
    in_ch.plain_right <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_plain(l, r);
  endtask

  task automatic feed_blocks(int count, int pause_at);
    int burst;
    int gap;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 16);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          send_block(random_word(), random_word());
          sent++;
          if (sent == pause_at) begin
            in_ch.valid <= 1'b0;
            drain();
          end
        end
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // result side: check at each accepting edge, then pick next ready
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         tick;
    bit         hold_done;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_cipher(out_ch.cipher_left, out_ch.cipher_right);
      end
      tick++;
      // one long hold-off so the pipeline backs up into the input
      if (!hold_done && sb.received >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:     out_ch.ready <= 1'b1;
          SINK_RANDOM:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
          SINK_PERIODIC: out_ch.ready <= ((tick % 7) < 3);
          default:       out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    word_t plain_l [20];
    word_t plain_r [20];
    plain_l = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'haaaa_aaaa, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
                32'h0123_4567, 32'h4142_4344, 32'h7fff_ffff, 32'hfedc_ba98,
                32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'h8000_0000, 32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555};
    plain_r = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h8000_0000,
                32'h89ab_cdef, 32'h4546_4748, 32'h8000_0000, 32'h7654_3210,
                32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa};
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= KEY_IDX_0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.plain_left  <= '0;
    in_ch.plain_right <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero key straight out of reset
    for (int i = 0; i < 12; i++) send_block(plain_l[i], plain_r[i]);
    in_ch.valid <= 1'b0;

    set_keys('1, '1, '1, '1);
    for (int i = 12; i < 20; i++) send_block(plain_l[i], plain_r[i]);
    in_ch.valid <= 1'b0;

    set_keys(32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f);
    feed_blocks(300, 0);
    set_keys(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    feed_blocks(300, 0);
    set_keys($urandom, $urandom, $urandom, $urandom);
    feed_blocks(300, 120);
    set_keys(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    feed_blocks(300, 0);
    set_keys($urandom, $urandom, $urandom, $urandom);
    feed_blocks(300, 0);
    set_keys('0, '0, '0, '0);
    feed_blocks(280, 0);

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/xtea_pkg.sv
hdl/xtea_in_if.sv
hdl/xtea_out_if.sv
hdl/xtea_block_encrypt_core.sv
test/tb_top.sv
